@@ rtl/stb_pkg.sv @@
// ----------------------------------------------------------------------------
// stb_pkg: shared types and constants for the software timer bank
// Operation and result codes, field widths and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int OP_W      = 2;
    localparam int KIND_W    = 3;
    localparam int SLOT_W    = 3;
    localparam int TIME_W    = 32;
    localparam int PER_MS_W  = 22;
    localparam int TIDX_W    = 3;
    // wide enough to hold any slot index or count up to 32 slots
    localparam int CNT_W     = 6;
    // fire counter for one pump
    localparam int RES_W     = 3;
    localparam int MAX_RESULTS = 6;
    localparam int US_PER_MS = 1000;

    // operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUMP  = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STARTED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NO_SLOT     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ZERO_PERIOD = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOPPED     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE_DUE    = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic              load;       // capture the input beat
        logic              mul;        // period in ms * 1000
        logic              start_wr;   // claim lowest free slot
        logic              stop_wr;    // free the addressed slot
        logic              scan_clr;   // restart the due scan
        logic              scan_step;  // check one slot for due
        logic              fire_add;   // deadline + period
        logic              fire_wr;    // commit the fire update
        logic              emit;       // load the result register
        logic [KIND_W-1:0] kind;
        logic              last;
    } stb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            zero_period;
        logic            free_found;
        logic            scan_last;
        logic            due_any;
        logic            due_more;
        logic            out_free;
    } stb_status_t;

endpackage

@@ rtl/software_timer_bank.sv @@
// ----------------------------------------------------------------------------
// software_timer_bank: bank of one-shot / repeating microsecond timers
// Top level joining the sequencing controller and the slot datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat: start, stop or
//   pump, each carrying the current 32-bit microsecond time in now_us.
//   Output channel (out_valid/out_ready) returns result beats; last marks
//   the final beat of a command. Start and stop give one beat, a pump gives
//   one beat per fired slot (up to six) or a single nothing-due beat.
//   Commands are handled one at a time. When the result register is loaded,
//   the beat is offered from the next cycle. A pump scans every slot
//   through one compare unit, one slot per cycle, then handles each fired
//   slot with an add step and a write step that loads its beat.
//   The input is ready again in the cycle after the last beat is loaded
//   into the output register, even while that beat is not yet taken.
//   Reset clears all slots to free, the active count to zero and drops
//   out_valid. A stalled receiver holds the result register and the
//   sequence waits; no beat is dropped.
// ----------------------------------------------------------------------------
module software_timer_bank #(
    parameter int NUM_TIMERS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [stb_pkg::OP_W-1:0]       operation,
    input  logic [stb_pkg::TIME_W-1:0]     now_us,
    input  logic [stb_pkg::PER_MS_W-1:0]   timer_period,
    input  logic                           repeat_req,
    input  logic [stb_pkg::TIDX_W-1:0]     timer_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [stb_pkg::KIND_W-1:0]     kind,
    output logic [stb_pkg::SLOT_W-1:0]     slot,
    output logic [stb_pkg::SLOT_W-1:0]     active_count,
    output logic                           last
);

    stb_pkg::stb_cmd_t    cmd;
    stb_pkg::stb_status_t status;

    stb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    stb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .now_us       (now_us),
        .timer_period (timer_period),
        .repeat_req   (repeat_req),
        .timer_index  (timer_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot         (slot),
        .active_count (active_count),
        .last         (last)
    );

endmodule

@@ rtl/stb_datapath.sv @@
// ----------------------------------------------------------------------------
// stb_datapath: slot storage, arithmetic and result register
// Holds per-slot state, does one compare-and-update per cycle under
// controller command, and drives the output beat.
// ----------------------------------------------------------------------------
module stb_datapath #(
    parameter int NUM_TIMERS = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  stb_pkg::stb_cmd_t              cmd,
    output stb_pkg::stb_status_t           status,
    input  logic [stb_pkg::OP_W-1:0]       operation,
    input  logic [stb_pkg::TIME_W-1:0]     now_us,
    input  logic [stb_pkg::PER_MS_W-1:0]   timer_period,
    input  logic                           repeat_req,
    input  logic [stb_pkg::TIDX_W-1:0]     timer_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [stb_pkg::KIND_W-1:0]     kind,
    output logic [stb_pkg::SLOT_W-1:0]     slot,
    output logic [stb_pkg::SLOT_W-1:0]     active_count,
    output logic                           last
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int TW = stb_pkg::TIME_W;
    localparam int CW = stb_pkg::CNT_W;

    // captured input beat
    logic [stb_pkg::OP_W-1:0]     op_reg;
    logic [TW-1:0]                now_reg;
    logic [stb_pkg::PER_MS_W-1:0] per_ms_reg;
    logic                         rep_req_reg;
    logic [stb_pkg::TIDX_W-1:0]   tidx_reg;

    // slot state
    logic [NUM_TIMERS-1:0] used_reg;
    logic [NUM_TIMERS-1:0] slot_rep_reg;
    logic [TW-1:0]         period_reg   [NUM_TIMERS];
    logic [TW-1:0]         deadline_reg [NUM_TIMERS];

    // scan and fire working registers
    logic [NUM_TIMERS-1:0] due_reg;
    logic [IW-1:0]         scan_idx_reg;
    logic [TW-1:0]         per_us_reg;
    logic [TW-1:0]         nd_reg;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;

    // result register
    logic                           out_valid_reg;
    logic [stb_pkg::KIND_W-1:0]     kind_reg;
    logic [stb_pkg::SLOT_W-1:0]     slot_reg;
    logic [stb_pkg::SLOT_W-1:0]     act_reg;
    logic                           last_reg;

    logic [IW-1:0]         free_idx;
    logic                  free_found;
    logic [IW-1:0]         fire_idx;
    logic [IW-1:0]         rd_idx;
    logic [TW-1:0]         dl_rd;
    logic [TW-1:0]         per_rd;
    logic [TW-1:0]         due_diff;
    logic [TW-1:0]         catch_diff;
    logic [TW-1:0]         fire_dl;
    logic [CW-1:0]         tidx_ext;
    logic [IW-1:0]         stop_idx;
    logic                  stop_hit;
    logic                  stop_dec;
    logic [CW-1:0]         free_ext;
    logic [CW-1:0]         fire_ext;
    logic [stb_pkg::SLOT_W-1:0] slot_sel;
    logic                  out_free;

    // lowest free slot
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx   = IW'(i);
                free_found = 1'b1;
            end
        end
    end

    // lowest pending due slot
    always_comb
    begin
        fire_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (due_reg[i])
            begin
                fire_idx = IW'(i);
            end
        end
    end

    // slot reads: one deadline port, one period port
    assign rd_idx     = cmd.scan_step ? scan_idx_reg : fire_idx;
    assign dl_rd      = deadline_reg[rd_idx];
    assign per_rd     = period_reg[fire_idx];
    assign due_diff   = now_reg - dl_rd;
    assign catch_diff = now_reg - nd_reg;
    // still overdue after one period: restart from now
    assign fire_dl    = catch_diff[TW-1] ? nd_reg : (now_reg + per_rd);

    // stop target
    assign tidx_ext = CW'(tidx_reg);
    assign stop_hit = tidx_ext < CW'(NUM_TIMERS);
    assign stop_idx = tidx_ext[IW-1:0];
    assign stop_dec = stop_hit && used_reg[stop_idx];

    // active count after this beat
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.start_wr)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.stop_wr && stop_dec)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.fire_wr && !slot_rep_reg[fire_idx])
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // slot field of the result
    assign free_ext = CW'(free_idx);
    assign fire_ext = CW'(fire_idx);
    always_comb
    begin
        if (cmd.kind == stb_pkg::KIND_STARTED)
        begin
            slot_sel = free_ext[stb_pkg::SLOT_W-1:0];
        end
        else if (cmd.kind == stb_pkg::KIND_FIRED)
        begin
            slot_sel = fire_ext[stb_pkg::SLOT_W-1:0];
        end
        else
        begin
            slot_sel = '0;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            slot_rep_reg  <= '0;
            due_reg       <= '0;
            scan_idx_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.start_wr)
            begin
                used_reg[free_idx]     <= 1'b1;
                slot_rep_reg[free_idx] <= rep_req_reg;
            end
            if (cmd.stop_wr && stop_hit)
            begin
                used_reg[stop_idx] <= 1'b0;
            end
            if (cmd.scan_clr)
            begin
                due_reg      <= '0;
                scan_idx_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                due_reg[scan_idx_reg] <= used_reg[scan_idx_reg] && !due_diff[TW-1];
                scan_idx_reg          <= scan_idx_reg + 1'b1;
            end
            if (cmd.fire_wr)
            begin
                due_reg[fire_idx] <= 1'b0;
                if (!slot_rep_reg[fire_idx])
                begin
                    used_reg[fire_idx] <= 1'b0;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            now_reg     <= now_us;
            per_ms_reg  <= timer_period;
            rep_req_reg <= repeat_req;
            tidx_reg    <= timer_index;
        end
        if (cmd.mul)
        begin
            per_us_reg <= TW'(per_ms_reg) * TW'(stb_pkg::US_PER_MS);
        end
        if (cmd.start_wr)
        begin
            period_reg[free_idx]   <= per_us_reg;
            deadline_reg[free_idx] <= now_reg + per_us_reg;
        end
        if (cmd.fire_add)
        begin
            nd_reg <= dl_rd + per_rd;
        end
        if (cmd.fire_wr)
        begin
            deadline_reg[fire_idx] <= fire_dl;
        end
        if (cmd.emit)
        begin
            kind_reg <= cmd.kind;
            slot_reg <= slot_sel;
            act_reg  <= cnt_next[stb_pkg::SLOT_W-1:0];
            last_reg <= cmd.last;
        end
    end

    // status to the controller
    assign status.op          = op_reg;
    assign status.zero_period = (per_ms_reg == '0);
    assign status.free_found  = free_found;
    assign status.scan_last   = (scan_idx_reg == IW'(NUM_TIMERS - 1));
    assign status.due_any     = |due_reg;
    assign status.due_more    = |(due_reg & (due_reg - 1'b1));
    assign status.out_free    = out_free;

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign slot         = slot_reg;
    assign active_count = act_reg;
    assign last         = last_reg;

endmodule

@@ rtl/stb_ctrl.sv @@
// ----------------------------------------------------------------------------
// stb_ctrl: sequencing state machine for the software timer bank
// Decodes the captured operation and steps the datapath through start,
// stop and the slot-by-slot pump scan.
// ----------------------------------------------------------------------------
module stb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  stb_pkg::stb_status_t  status,
    output stb_pkg::stb_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ZERO,
        S_START_MUL,
        S_START_WR,
        S_STOP,
        S_SCAN,
        S_PICK,
        S_NONE,
        S_FIRE_ADD,
        S_FIRE_WR
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [stb_pkg::RES_W-1:0]   k_reg;
    logic [stb_pkg::RES_W-1:0]   k_next;
    logic                        fire_last;

    assign in_ready  = (state_reg == S_IDLE);
    assign fire_last = !status.due_more ||
                       (k_reg == stb_pkg::RES_W'(stb_pkg::MAX_RESULTS - 1));

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (status.op == stb_pkg::OP_START)
                begin
                    state_next = status.zero_period ? S_ZERO : S_START_MUL;
                end
                else if (status.op == stb_pkg::OP_STOP)
                begin
                    state_next = S_STOP;
                end
                else if (status.op == stb_pkg::OP_PUMP)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_ZERO:
            begin
                cmd.kind = stb_pkg::KIND_ZERO_PERIOD;
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_START_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_START_WR;
            end
            S_START_WR:
            begin
                cmd.kind = status.free_found ? stb_pkg::KIND_STARTED
                                             : stb_pkg::KIND_NO_SLOT;
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.start_wr = status.free_found;
                    state_next   = S_IDLE;
                end
            end
            S_STOP:
            begin
                cmd.kind = stb_pkg::KIND_STOPPED;
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.stop_wr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                k_next     = '0;
                state_next = status.due_any ? S_FIRE_ADD : S_NONE;
            end
            S_NONE:
            begin
                cmd.kind = stb_pkg::KIND_NONE_DUE;
                cmd.last = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FIRE_ADD:
            begin
                cmd.fire_add = 1'b1;
                state_next   = S_FIRE_WR;
            end
            S_FIRE_WR:
            begin
                cmd.kind = stb_pkg::KIND_FIRED;
                cmd.last = fire_last;
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.fire_wr = 1'b1;
                    k_next      = k_reg + 1'b1;
                    state_next  = fire_last ? S_IDLE : S_FIRE_ADD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and fire count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

endmodule

@@ rtl/stb_checker.sv @@
// ----------------------------------------------------------------------------
// stb_checker: port-level checks for the software timer bank
// Watches the top-level ports and flags result beats that break the
// block's encoding rules.
// ----------------------------------------------------------------------------
module stb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [stb_pkg::KIND_W-1:0]  kind,
    input logic [stb_pkg::SLOT_W-1:0]  slot,
    input logic [stb_pkg::SLOT_W-1:0]  active_count,
    input logic                        last
);

    // stalled beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // only defined kinds leave the block
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= stb_pkg::KIND_NONE_DUE)
        else $error("undefined result kind");

    // single-beat kinds carry no slot and close their command
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == stb_pkg::KIND_NO_SLOT || kind == stb_pkg::KIND_ZERO_PERIOD ||
                      kind == stb_pkg::KIND_STOPPED || kind == stb_pkg::KIND_NONE_DUE)
        |-> slot == '0 && last)
        else $error("single-beat result malformed");

    // a started timer is counted
    a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == stb_pkg::KIND_STARTED |-> last && active_count != '0)
        else $error("start result with zero active count");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .slot         (slot),
    .active_count (active_count),
    .last         (last)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for software_timer_bank
// Sends start, stop and pump commands with random idle bursts on both
// channels. A behavioral copy of the slot bank predicts every result beat,
// and each accepted result beat is compared in order against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TIMERS      = 6;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    // operation code that the block drops without a result
    localparam logic [stb_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [stb_pkg::KIND_W-1:0] kind;
        logic [stb_pkg::SLOT_W-1:0] slot;
        logic [stb_pkg::SLOT_W-1:0] active;
        logic                       is_last;
    } timer_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [stb_pkg::OP_W-1:0]     operation;
    logic [stb_pkg::TIME_W-1:0]   now_us;
    logic [stb_pkg::PER_MS_W-1:0] timer_period;
    logic                         repeat_req;
    logic [stb_pkg::TIDX_W-1:0]   timer_index;
    logic                         out_valid;
    logic                         out_ready;
    logic [stb_pkg::KIND_W-1:0]   kind;
    logic [stb_pkg::SLOT_W-1:0]   slot;
    logic [stb_pkg::SLOT_W-1:0]   active_count;
    logic                         res_last;

    // predicted slot bank
    bit                         bank_used        [TIMERS];
    bit                         bank_repeat      [TIMERS];
    logic [stb_pkg::TIME_W-1:0] bank_period_us   [TIMERS];
    logic [stb_pkg::TIME_W-1:0] bank_deadline_us [TIMERS];

    timer_result_t              pending_results[$];
    int                         error_count  = 0;
    int                         quiet_cycles = 0;
    bit                         idle_en      = 1'b1;
    logic [stb_pkg::TIME_W-1:0] sim_clock_us = '0;

    software_timer_bank #(
        .NUM_TIMERS(TIMERS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .now_us       (now_us),
        .timer_period (timer_period),
        .repeat_req   (repeat_req),
        .timer_index  (timer_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .slot         (slot),
        .active_count (active_count),
        .last         (res_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $time, msg);
    endfunction

    function automatic int used_count();
        int n;
        int i;
        n = 0;
        for (i = 0; i < TIMERS; i++)
            if (bank_used[i])
                n++;
        return n;
    endfunction

    // wrap-safe "now is at or past t"
    function automatic bit is_reached(logic [stb_pkg::TIME_W-1:0] now,
            logic [stb_pkg::TIME_W-1:0] t);
        logic [stb_pkg::TIME_W-1:0] diff;
        diff = now - t;
        return !diff[stb_pkg::TIME_W-1];
    endfunction

    function automatic void push_result(logic [stb_pkg::KIND_W-1:0] k, int s, bit lst);
        timer_result_t r;
        int            n;
        n         = used_count();
        r.kind    = k;
        r.slot    = s[stb_pkg::SLOT_W-1:0];
        r.active  = n[stb_pkg::SLOT_W-1:0];
        r.is_last = lst;
        pending_results.push_back(r);
    endfunction

    // update the slot bank for one accepted command and queue its result beats
    function automatic void predict_timer_cmd(logic [stb_pkg::OP_W-1:0] op,
            logic [stb_pkg::TIME_W-1:0] now, logic [stb_pkg::PER_MS_W-1:0] per_ms,
            logic rep, logic [stb_pkg::TIDX_W-1:0] idx);
        int                         fired;
        int                         free_slot;
        int                         i;
        logic [stb_pkg::TIME_W-1:0] per_us;
        timer_result_t              tail;
        fired     = 0;
        free_slot = -1;
        per_us    = stb_pkg::TIME_W'(per_ms);
        per_us    = per_us * stb_pkg::TIME_W'(stb_pkg::US_PER_MS);
        case (op)
            stb_pkg::OP_START:
            begin
                if (per_ms == '0)
                    push_result(stb_pkg::KIND_ZERO_PERIOD, 0, 1'b1);
                else
                begin
                    for (i = TIMERS - 1; i >= 0; i--)
                        if (!bank_used[i])
                            free_slot = i;
                    if (free_slot < 0)
                        push_result(stb_pkg::KIND_NO_SLOT, 0, 1'b1);
                    else
                    begin
                        bank_period_us[free_slot]   = per_us;
                        bank_deadline_us[free_slot] = now + per_us;
                        bank_used[free_slot]        = 1'b1;
                        bank_repeat[free_slot]      = rep;
                        push_result(stb_pkg::KIND_STARTED, free_slot, 1'b1);
                    end
                end
            end
            stb_pkg::OP_STOP:
            begin
                if (idx < TIMERS)
                    bank_used[idx] = 1'b0;
                push_result(stb_pkg::KIND_STOPPED, 0, 1'b1);
            end
            stb_pkg::OP_PUMP:
            begin
                // scan in index order, at most one catch-up per slot
                for (i = 0; i < TIMERS && fired < stb_pkg::MAX_RESULTS; i++)
                begin
                    if (bank_used[i] && is_reached(now, bank_deadline_us[i]))
                    begin
                        bank_deadline_us[i] = bank_deadline_us[i] + bank_period_us[i];
                        if (is_reached(now, bank_deadline_us[i]))
                            bank_deadline_us[i] = now + bank_period_us[i];
                        if (!bank_repeat[i])
                            bank_used[i] = 1'b0;
                        push_result(stb_pkg::KIND_FIRED, i, 1'b0);
                        fired++;
                    end
                end
                if (fired == 0)
                    push_result(stb_pkg::KIND_NONE_DUE, 0, 1'b1);
                else
                begin
                    tail         = pending_results.pop_back();
                    tail.is_last = 1'b1;
                    pending_results.push_back(tail);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // drive one command beat, hold it until accepted, then predict it
    task automatic send_timer_cmd(logic [stb_pkg::OP_W-1:0] op,
            logic [stb_pkg::TIME_W-1:0] now, logic [stb_pkg::PER_MS_W-1:0] per_ms,
            logic rep, logic [stb_pkg::TIDX_W-1:0] idx);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        operation    <= op;
        now_us       <= now;
        timer_period <= per_ms;
        repeat_req   <= rep;
        timer_index  <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        predict_timer_cmd(op, now, per_ms, rep, idx);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_start_and_full_bank();
        // empty bank pump, zero period, extremes of period and time, full bank
        send_timer_cmd(stb_pkg::OP_PUMP,  32'd0,          22'd0,       1'b0, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd0,          22'd0,       1'b1, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd0,          22'd1,       1'b0, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'hFFFF_FFFF,  22'h3F_FFFF, 1'b1, 3'd7);
        send_timer_cmd(stb_pkg::OP_START, 32'd0,          22'd1,       1'b1, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd0,          22'd2,       1'b0, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd0,          22'd1,       1'b1, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd0,          22'd3,       1'b1, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd0,          22'd5,       1'b1, 3'd0);
        wait_drained();
    endtask

    task automatic test_pump_catch_up();
        // several fires in one pump, then a late pump that forces catch-up
        send_timer_cmd(stb_pkg::OP_PUMP, 32'd1000,   22'd0, 1'b0, 3'd0);
        send_timer_cmd(stb_pkg::OP_PUMP, 32'd100000, 22'd0, 1'b0, 3'd0);
        wait_drained();
    endtask

    task automatic test_stop_and_ignored();
        // out-of-range indices, stop of a free slot, stop of a live slot, ignored op
        send_timer_cmd(stb_pkg::OP_STOP, 32'd100100,    22'd0,       1'b0, 3'd7);
        send_timer_cmd(stb_pkg::OP_STOP, 32'd100100,    22'd0,       1'b0, 3'd6);
        send_timer_cmd(stb_pkg::OP_STOP, 32'd100100,    22'd0,       1'b0, 3'd0);
        send_timer_cmd(stb_pkg::OP_STOP, 32'd100100,    22'd0,       1'b0, 3'd5);
        send_timer_cmd(OP_IGNORED,       32'h5555_5555, 22'h2A_AAAA, 1'b1, 3'd5);
        wait_drained();
    endtask

    task automatic test_pump_wrap_and_full();
        // pump at the top of the clock range, then six fires in one pump
        send_timer_cmd(stb_pkg::OP_PUMP,  32'hFFFF_FFFF, 22'd0, 1'b0, 3'd0);
        send_timer_cmd(stb_pkg::OP_STOP,  32'd200000,    22'd0, 1'b0, 3'd1);
        send_timer_cmd(stb_pkg::OP_START, 32'd200000,    22'd1, 1'b0, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd200000,    22'd1, 1'b1, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd200000,    22'd1, 1'b0, 3'd0);
        send_timer_cmd(stb_pkg::OP_START, 32'd200000,    22'd1, 1'b1, 3'd0);
        send_timer_cmd(stb_pkg::OP_PUMP,  32'd300000,    22'd0, 1'b0, 3'd0);
        wait_drained();
    endtask

    // mostly short periods and small time steps so timers keep firing;
    // occasional long jumps, wraps and random times shake the deadlines
    task automatic run_random_items(int count);
        int                           sent;
        int                           pick;
        logic [stb_pkg::OP_W-1:0]     op;
        logic [stb_pkg::PER_MS_W-1:0] per_ms;
        logic                         rep;
        logic [stb_pkg::TIDX_W-1:0]   idx;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = OP_IGNORED;
            else if (pick < 38)
                op = stb_pkg::OP_START;
            else if (pick < 58)
                op = stb_pkg::OP_STOP;
            else
                op = stb_pkg::OP_PUMP;

            pick = $urandom_range(0, 99);
            if (pick < 80)
                sim_clock_us = sim_clock_us + $urandom_range(0, 4000);
            else if (pick < 94)
                sim_clock_us = sim_clock_us + $urandom_range(4001, 60000);
            else if (pick < 98)
                sim_clock_us = sim_clock_us + $urandom;
            else
                sim_clock_us = $urandom;

            pick = $urandom_range(0, 99);
            if (pick < 8)
                per_ms = '0;
            else if (pick < 75)
                per_ms = stb_pkg::PER_MS_W'($urandom_range(1, 20));
            else if (pick < 90)
                per_ms = stb_pkg::PER_MS_W'($urandom_range(21, 5000));
            else
                per_ms = stb_pkg::PER_MS_W'($urandom_range(0, 22'h3F_FFFF));

            rep = 1'($urandom_range(0, 1));
            idx = stb_pkg::TIDX_W'($urandom_range(0, 7));
            send_timer_cmd(op, sim_clock_us, per_ms, rep, idx);
            if (op != OP_IGNORED)
                sent++;
        end
    endtask

    task automatic test_random_traffic();
        sim_clock_us = 32'hFFF0_0000;
        run_random_items(320);
        wait_drained();
    endtask

    task automatic test_random_quiet();
        // both channels run without idle bursts
        idle_en = 1'b0;
        run_random_items(80);
        wait_drained();
    endtask

    // receiver: random stall bursts on out_ready
    initial
    begin
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (idle_en && rst_n && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // result check: each accepted beat against the oldest prediction
    always @(posedge clk)
    begin : result_check
        timer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                note_error($sformatf("unexpected beat: kind=%0d slot=%0d active=%0d last=%0b",
                    kind, slot, active_count, res_last));
            else
            begin
                want = pending_results.pop_front();
                if (want.kind !== kind || want.slot !== slot ||
                    want.active !== active_count || want.is_last !== res_last)
                    note_error($sformatf({"beat mismatch: expected kind=%0d slot=%0d ",
                        "active=%0d last=%0b, got kind=%0d slot=%0d active=%0d last=%0b"},
                        want.kind, want.slot, want.active, want.is_last,
                        kind, slot, active_count, res_last));
            end
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        operation    <= stb_pkg::OP_START;
        now_us       <= '0;
        timer_period <= '0;
        repeat_req   <= 1'b0;
        timer_index  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_start_and_full_bank();
        test_pump_catch_up();
        test_stop_and_ignored();
        test_pump_wrap_and_full();
        test_random_traffic();
        test_random_quiet();

        // let any stray beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
